// File: rtl/fpe_pkg.sv
// shared types, constants, plane-selection helpers and saturation/magnitude helpers for the frustum plane extractor
package fpe_pkg;

  localparam int unsigned ENTRY_W = 32;
  localparam int unsigned ROWS = 4;
  localparam int unsigned COLS = 4;
  localparam int unsigned PIDX_W = 3;

  localparam logic [PIDX_W-1:0] PLANE_LEFT   = 3'd0;
  localparam logic [PIDX_W-1:0] PLANE_RIGHT  = 3'd1;
  localparam logic [PIDX_W-1:0] PLANE_BOTTOM = 3'd2;
  localparam logic [PIDX_W-1:0] PLANE_TOP    = 3'd3;
  localparam logic [PIDX_W-1:0] PLANE_NEAR   = 3'd4;
  localparam logic [PIDX_W-1:0] PLANE_FAR    = 3'd5;

  localparam logic [1:0] COL_LAST = 2'd3;

  localparam logic [ENTRY_W-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [ENTRY_W-1:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_BASE
  } plane_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COMP,
    ST_SQUARE,
    ST_CHECK,
    ST_SQRT,
    ST_DIV,
    ST_EMIT
  } state_t;

  function automatic logic [1:0] plane_row(input logic [PIDX_W-1:0] p);
    logic [1:0] r;
    case (p)
      PLANE_LEFT, PLANE_RIGHT: r = 2'd0;
      PLANE_BOTTOM, PLANE_TOP: r = 2'd1;
      default:                 r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic plane_op_t plane_op(input logic [PIDX_W-1:0] p);
    plane_op_t o;
    case (p)
      PLANE_LEFT, PLANE_BOTTOM: o = OP_ADD;
      PLANE_NEAR:               o = OP_BASE;
      default:                  o = OP_SUB;
    endcase
    return o;
  endfunction

  function automatic logic [ENTRY_W-1:0] sat33(input logic [ENTRY_W:0] v);
    logic [ENTRY_W-1:0] r;
    if (v[ENTRY_W] != v[ENTRY_W-1]) begin
      r = v[ENTRY_W] ? Q_MIN : Q_MAX;
    end else begin
      r = v[ENTRY_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [ENTRY_W-1:0] magnitude(input logic [ENTRY_W-1:0] v);
    return v[ENTRY_W-1] ? (~v + 32'd1) : v;
  endfunction

endpackage

// File: rtl/fpe_if.sv
// valid/ready channel interfaces for matrix columns in and planes out
interface fpe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  column;
  logic [31:0] entry_row0;
  logic [31:0] entry_row1;
  logic [31:0] entry_row2;
  logic [31:0] entry_row3;

  modport source (output valid, column, entry_row0, entry_row1, entry_row2, entry_row3,
                  input ready);
  modport sink (input valid, column, entry_row0, entry_row1, entry_row2, entry_row3,
                output ready);
endinterface

interface fpe_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  plane_index;
  logic [31:0] plane_a;
  logic [31:0] plane_b;
  logic [31:0] plane_c;
  logic [31:0] plane_d;
  logic        last_plane;

  modport source (output valid, plane_index, plane_a, plane_b, plane_c, plane_d, last_plane,
                  input ready);
  modport sink (input valid, plane_index, plane_a, plane_b, plane_c, plane_d, last_plane,
                output ready);
endinterface

// File: rtl/fpe_sqrt.sv
// bit-serial integer square root, one root bit per cycle
module fpe_sqrt
  import fpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad;
  logic [33:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [35:0] trial_rem;
  logic [35:0] trial_sub;
  logic [35:0] trial_diff;

  // bring down two radicand bits, try (root<<2)|1
  assign trial_rem  = {rem, rad[63:62]};
  assign trial_sub  = {2'b00, root, 2'b01};
  assign trial_diff = trial_rem - trial_sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[61:0], 2'b00};
        if (trial_rem >= trial_sub) begin
          rem  <= trial_diff[33:0];
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= trial_rem[33:0];
          root <= {root[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/fpe_div.sv
// bit-serial restoring divider lane: round(value * 2^frac / len), saturated
module fpe_div
  import fpe_pkg::*;
#(
  parameter int unsigned FRAC_W = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] value,
  input  logic [31:0] len,
  output logic        done,
  output logic [31:0] result
);

  localparam int unsigned NUM_W = ENTRY_W + FRAC_W;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] q;
  logic [32:0]      rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             neg;
  logic [31:0]      mag;
  logic [32:0]      trial;
  logic             hi;

  assign mag   = magnitude(value);
  assign trial = {rem[31:0], num[NUM_W-1]};
  assign hi    = |q[NUM_W-1:ENTRY_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= value[31];
        // rounding half away from zero: add len/2 before dividing
        num  <= {mag, {FRAC_W{1'b0}}} + NUM_W'(len[31:1]);
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        num <= {num[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, len}) begin
          rem <= trial - {1'b0, len};
          q   <= {q[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg) begin
      if (hi || (q[31] && (|q[30:0]))) begin
        result = Q_MIN;
      end else begin
        result = ~q[31:0] + 32'd1;
      end
    end else begin
      if (hi || q[31]) begin
        result = Q_MAX;
      end else begin
        result = q[31:0];
      end
    end
  end

endmodule

// File: rtl/frustum_plane_extract_top.sv
// frustum plane extraction from a column-major view-projection matrix
// columns 0..2 are only stored; after column 3 each plane goes through reading, squaring,
// a check, serial square root, serial division (four lanes in parallel) and loading
// the output, and no new matrix is taken until the far plane is loaded; a zero-length
// normal skips both the square root and the division
// synchronous reset returns to idle with no planes pending; the matrix store is not cleared
module frustum_plane_extract_top
  import fpe_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input logic      clk,
  input logic      rst,
  fpe_in_if.sink   in_item,
  fpe_out_if.source out_plane
);

  logic [4*ENTRY_W-1:0] store [COLS];
  logic [4*ENTRY_W-1:0] rdata;

  state_t state, state_next;
  logic [PIDX_W-1:0] p;
  logic [1:0]        k;
  logic [31:0]       comp [4];
  logic [63:0]       prod;
  logic [63:0]       sum;
  logic              norm;
  logic              out_valid;

  logic        accept;
  logic        sqrt_start, sqrt_done, div_start, load_out;
  logic [31:0] root;
  logic [3:0]  div_done;
  logic [31:0] div_res [4];
  logic [31:0] base, w;
  logic [32:0] raw;
  logic [31:0] mag;

  assign accept        = in_item.valid && in_item.ready;
  assign in_item.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (accept) begin
      store[in_item.column] <= {in_item.entry_row3, in_item.entry_row2,
                                in_item.entry_row1, in_item.entry_row0};
    end
    rdata <= store[k];
  end

  assign base = rdata[32*plane_row(p) +: 32];
  assign w    = rdata[127:96];
  assign mag  = magnitude(comp[k]);

  always_comb begin
    case (plane_op(p))
      OP_ADD:  raw = {w[31], w} + {base[31], base};
      OP_SUB:  raw = {w[31], w} - {base[31], base};
      default: raw = {base[31], base};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && in_item.column == COL_LAST) state_next = ST_READ;
      end
      ST_READ: state_next = ST_COMP;
      ST_COMP: begin
        state_next = (k == 2'd3) ? ST_SQUARE : ST_READ;
      end
      ST_SQUARE: begin
        if (k == 2'd3) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sum == 64'd0) begin
          state_next = ST_EMIT;
        end else begin
          sqrt_start = 1'b1;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (&div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || out_plane.ready) begin
          load_out   = 1'b1;
          state_next = (p == PLANE_FAR) ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      p         <= '0;
      k         <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_plane.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          p <= PLANE_LEFT;
          k <= '0;
        end
        ST_COMP: k <= k + 2'd1;
        ST_SQUARE: k <= k + 2'd1;
        ST_EMIT: begin
          if (load_out) begin
            p <= p + 3'd1;
            k <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_COMP) begin
      comp[k] <= sat33(raw);
      sum     <= '0;
    end
    // one product a cycle, accumulated the cycle after
    if (state == ST_SQUARE) begin
      prod <= (k == 2'd3) ? 64'd0 : 64'(mag) * 64'(mag);
      if (k != 2'd0) sum <= sum + prod;
    end
    if (state == ST_CHECK) norm <= (sum != 64'd0);
    if (load_out) begin
      out_plane.plane_index <= p;
      out_plane.last_plane  <= (p == PLANE_FAR);
      out_plane.plane_a     <= norm ? div_res[0] : comp[0];
      out_plane.plane_b     <= norm ? div_res[1] : comp[1];
      out_plane.plane_c     <= norm ? div_res[2] : comp[2];
      out_plane.plane_d     <= norm ? div_res[3] : comp[3];
    end
  end

  assign out_plane.valid = out_valid;

  fpe_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sum),
    .done     (sqrt_done),
    .root     (root)
  );

  for (genvar i = 0; i < 4; i++) begin : g_lane
    fpe_div #(.FRAC_W(FRACTION_BITS)) u_div (
      .clk    (clk),
      .rst    (rst),
      .start  (div_start),
      .value  (comp[i]),
      .len    (root),
      .done   (div_done[i]),
      .result (div_res[i])
    );
  end

endmodule

// File: rtl/fpe_checker.sv
// port-level checks for the frustum plane extractor, bound to the top level
module fpe_checker
  import fpe_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_column,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_index,
  input logic [31:0] out_a,
  input logic        out_last
);

  // last beat flag only on the far plane
  a_last_far: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_index == PLANE_FAR)))
    else $error("last_plane disagrees with plane_index");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_index <= PLANE_FAR))
    else $error("plane_index out of range");

  // a final column starts plane work, so no beat is taken next cycle
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_column == COL_LAST) |=> !in_ready)
    else $error("input taken while planes are being built");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_index) && $stable(out_a)))
    else $error("stalled output beat changed");

endmodule

bind frustum_plane_extract_top fpe_checker u_fpe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_item.valid),
  .in_ready  (in_item.ready),
  .in_column (in_item.column),
  .out_valid (out_plane.valid),
  .out_ready (out_plane.ready),
  .out_index (out_plane.plane_index),
  .out_a     (out_plane.plane_a),
  .out_last  (out_plane.last_plane)
);
